@@ sv/qplt_pkg.sv @@
// Shared types, codes and helpers of the quote and parenthesis line tokenizer.
package qplt_pkg;

  // Results one input byte can cause at most
  localparam int unsigned MaxRes = 3;

  // Byte codes that steer the scanner
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] CountMax = 8'hFF;

  // Scanner state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_REG   = 4'b0010,
    MODE_QUOTE = 4'b0100,
    MODE_PAREN = 4'b1000
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DROP = 2'd2,
    KIND_LINE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    TYPE_REG   = 2'd0,
    TYPE_QUOTE = 2'd1,
    TYPE_PAREN = 2'd2
  } tok_type_e;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      out_kind;
    tok_type_e  tok_type;
    logic [7:0] tok_count;
    logic       run_last;
  } result_t;

  // All results of one byte, handed from the scanner to the output buffer
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [1:0]           num;
  } step_t;

  function automatic logic is_blank(logic [7:0] c);
    return ((c >= ChTab) && (c <= ChCr)) || (c == ChSpace);
  endfunction

  function automatic result_t mk_res(logic [7:0] b, kind_e k, tok_type_e t,
                                     logic [7:0] cnt);
    result_t r;
    r.out_byte  = b;
    r.out_kind  = k;
    r.tok_type  = t;
    r.tok_count = cnt;
    r.run_last  = 1'b0;
    return r;
  endfunction

endpackage

@@ sv/qplt_if.sv @@
// Handshake channels for input bytes and result words of the tokenizer.
interface qplt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface qplt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [1:0] tok_type;
  logic [7:0] tok_count;
  logic       run_last;

  modport source (output valid, output out_byte, output out_kind, output tok_type,
                  output tok_count, output run_last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input tok_type,
                input tok_count, input run_last, output ready);
endinterface

@@ sv/qplt_scan.sv @@
// Scanner state and per-byte next-state and result logic.
module qplt_scan
  import qplt_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] ch_i,
  input  logic       line_end_i,
  output step_t      step_o
);

  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);

  mode_e                 mode_q, mode_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [7:0]            total_q, total_d;

  // Work out the results and next state for the byte on offer
  always_comb begin
    result_t [MaxRes-1:0] res;
    logic [1:0]           n;
    res     = '0;
    n       = 2'd0;
    mode_d  = mode_q;
    depth_d = depth_q;
    total_d = total_q;

    unique case (mode_q)
      MODE_IDLE: begin
        if (is_blank(ch_i)) begin
          mode_d = MODE_IDLE;
        end else if (ch_i == ChQuote) begin
          mode_d = MODE_QUOTE;
        end else if (ch_i == ChOpen) begin
          mode_d  = MODE_PAREN;
          depth_d = DepthOne;
          res[n]  = mk_res(ch_i, KIND_DATA, TYPE_PAREN, 8'd0);
          n       = n + 2'd1;
        end else begin
          mode_d = MODE_REG;
          res[n] = mk_res(ch_i, KIND_DATA, TYPE_REG, 8'd0);
          n      = n + 2'd1;
        end
      end
      MODE_REG: begin
        if (is_blank(ch_i)) begin
          if (total_d != CountMax) total_d = total_d + 8'd1;
          mode_d = MODE_IDLE;
          res[n] = mk_res(8'd0, KIND_DONE, TYPE_REG, 8'd0);
        end else begin
          res[n] = mk_res(ch_i, KIND_DATA, TYPE_REG, 8'd0);
        end
        n = n + 2'd1;
      end
      MODE_QUOTE: begin
        if (ch_i == ChQuote) begin
          if (total_d != CountMax) total_d = total_d + 8'd1;
          mode_d = MODE_IDLE;
          res[n] = mk_res(8'd0, KIND_DONE, TYPE_QUOTE, 8'd0);
        end else begin
          res[n] = mk_res(ch_i, KIND_DATA, TYPE_QUOTE, 8'd0);
        end
        n = n + 2'd1;
      end
      MODE_PAREN: begin
        res[n] = mk_res(ch_i, KIND_DATA, TYPE_PAREN, 8'd0);
        n      = n + 2'd1;
        // Track nesting, saturating at both ends
        if (ch_i == ChOpen) begin
          if (depth_q != DepthMax) depth_d = depth_q + DepthOne;
        end else if (ch_i == ChClose) begin
          if (depth_q != '0) depth_d = depth_q - DepthOne;
        end
        if (depth_d == '0) begin
          if (total_d != CountMax) total_d = total_d + 8'd1;
          mode_d = MODE_IDLE;
          res[n] = mk_res(8'd0, KIND_DONE, TYPE_PAREN, 8'd0);
          n      = n + 2'd1;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase

    // Close any open token at line end, then report the line
    if (line_end_i) begin
      unique case (mode_d)
        MODE_REG: begin
          if (total_d != CountMax) total_d = total_d + 8'd1;
          res[n] = mk_res(8'd0, KIND_DONE, TYPE_REG, 8'd0);
          n      = n + 2'd1;
        end
        MODE_QUOTE: begin
          res[n] = mk_res(8'd0, KIND_DROP, TYPE_QUOTE, 8'd0);
          n      = n + 2'd1;
        end
        MODE_PAREN: begin
          if (total_d != CountMax) total_d = total_d + 8'd1;
          res[n] = mk_res(8'd0, KIND_DONE, TYPE_PAREN, 8'd0);
          n      = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      res[n]  = mk_res(8'd0, KIND_LINE, TYPE_REG, total_d);
      n       = n + 2'd1;
      mode_d  = MODE_IDLE;
      depth_d = '0;
      total_d = 8'd0;
    end

    // Flag the final word of this byte
    if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;

    step_o.res = res;
    step_o.num = n;
  end

  // Advance the state on an accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      depth_q <= '0;
      total_q <= 8'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      total_q <= total_d;
    end
  end

endmodule

@@ sv/qplt_outbuf.sv @@
// Result buffer that holds the words of one byte and hands them out in order.
module qplt_outbuf
  import qplt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  step_t      step_i,
  output logic       can_load_o,
  qplt_out_if.source out_o
);

  result_t [MaxRes-1:0] buf_q;
  logic [1:0]           cnt_q, cnt_d;
  logic [1:0]           rd_q, rd_d;
  logic                 pop;
  result_t              head;

  assign head = buf_q[rd_q];
  assign pop  = out_o.valid && out_o.ready;

  // Take a new byte once the last held word leaves this cycle
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.out_byte  = head.out_byte;
  assign out_o.out_kind  = head.out_kind;
  assign out_o.tok_type  = head.tok_type;
  assign out_o.tok_count = head.tok_count;
  assign out_o.run_last  = head.run_last;

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = step_i.num;
      rd_d  = 2'd0;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  // Hold the words of the latest byte
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= step_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

endmodule

@@ sv/quote_paren_line_tokenizer.sv @@
// The first result word of a byte appears in the cycle after the byte is taken.
// One byte per cycle while each byte yields at most one word and the output is ready;
// a byte with more words holds the input until the single-word output port takes its last.
// Words waiting on a stalled output are held in a three-entry result buffer.
// Reset (rst_ni low, asynchronous) empties the buffer and returns to between tokens.
module quote_paren_line_tokenizer
  import qplt_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qplt_in_if.sink   in_i,
  qplt_out_if.source out_o
);

  logic  accept;
  logic  can_load;
  step_t step;

  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  qplt_scan #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .ch_i      (in_i.ch),
    .line_end_i(in_i.line_end),
    .step_o    (step)
  );

  qplt_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .step_i    (step),
    .can_load_o(can_load),
    .out_o     (out_o)
  );

endmodule

@@ tb/qplt_checker.sv @@
// Scoreboard of the tokenizer: predicts result words from accepted bytes and compares them.
module qplt_checker
  import qplt_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  qplt_in_if   in_mon,
  qplt_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   words_o,
  output int   lines_o,
  output int   tokens_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [DEPTH_BITS-1:0] DepthTop = '1;

  // Own copy of the scanner state
  mode_e                 scan_mode;
  logic [DEPTH_BITS-1:0] nest_level;
  logic [7:0]            line_tokens;

  result_t expected_words[$];
  result_t head_word;

  function automatic logic blank_byte(logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  function automatic result_t token_word(logic [7:0] b, kind_e k, tok_type_e t,
                                         logic [7:0] cnt);
    result_t w;
    w = '{out_byte: b, out_kind: k, tok_type: t, tok_count: cnt, run_last: 1'b0};
    return w;
  endfunction

  // Count a committed token, holding at the top of the range
  task automatic commit_token();
    if (line_tokens != CountMax) line_tokens++;
  endtask

  // Advance the scanner by one byte and queue the words it causes
  task automatic scan_byte(input logic [7:0] c, input logic line_end);
    result_t step[$];
    case (scan_mode)
      MODE_IDLE: begin
        if (!blank_byte(c)) begin
          if (c == ChQuote) begin
            scan_mode = MODE_QUOTE;
          end else if (c == ChOpen) begin
            scan_mode  = MODE_PAREN;
            nest_level = DEPTH_BITS'(1);
            step.push_back(token_word(c, KIND_DATA, TYPE_PAREN, 8'd0));
          end else begin
            scan_mode = MODE_REG;
            step.push_back(token_word(c, KIND_DATA, TYPE_REG, 8'd0));
          end
        end
      end
      MODE_REG: begin
        if (blank_byte(c)) begin
          commit_token();
          scan_mode = MODE_IDLE;
          step.push_back(token_word(8'd0, KIND_DONE, TYPE_REG, 8'd0));
        end else begin
          step.push_back(token_word(c, KIND_DATA, TYPE_REG, 8'd0));
        end
      end
      MODE_QUOTE: begin
        if (c == ChQuote) begin
          commit_token();
          scan_mode = MODE_IDLE;
          step.push_back(token_word(8'd0, KIND_DONE, TYPE_QUOTE, 8'd0));
        end else begin
          step.push_back(token_word(c, KIND_DATA, TYPE_QUOTE, 8'd0));
        end
      end
      default: begin
        step.push_back(token_word(c, KIND_DATA, TYPE_PAREN, 8'd0));
        if (c == ChOpen && nest_level != DepthTop) nest_level++;
        else if (c == ChClose && nest_level != 0) nest_level--;
        if (nest_level == 0) begin
          commit_token();
          scan_mode = MODE_IDLE;
          step.push_back(token_word(8'd0, KIND_DONE, TYPE_PAREN, 8'd0));
        end
      end
    endcase

    // Close the line: an open quote is dropped, any other open token is kept
    if (line_end) begin
      case (scan_mode)
        MODE_REG: begin
          commit_token();
          step.push_back(token_word(8'd0, KIND_DONE, TYPE_REG, 8'd0));
        end
        MODE_QUOTE: step.push_back(token_word(8'd0, KIND_DROP, TYPE_QUOTE, 8'd0));
        MODE_PAREN: begin
          commit_token();
          step.push_back(token_word(8'd0, KIND_DONE, TYPE_PAREN, 8'd0));
        end
        default: ;
      endcase
      step.push_back(token_word(8'd0, KIND_LINE, TYPE_REG, line_tokens));
      lines_o++;
      tokens_o += line_tokens;
      scan_mode   = MODE_IDLE;
      nest_level  = '0;
      line_tokens = 8'd0;
    end

    if (step.size() > 0) step[step.size()-1].run_last = 1'b1;
    foreach (step[i]) expected_words.push_back(step[i]);
  endtask

  // Predict on accepted bytes first, then compare the accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode    = MODE_IDLE;
      nest_level   = '0;
      line_tokens  = 8'd0;
      expected_words.delete();
      fail_count_o = 0;
      words_o      = 0;
      lines_o      = 0;
      tokens_o     = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) scan_byte(in_mon.ch, in_mon.line_end);
      if (out_mon.valid && out_mon.ready) begin
        words_o++;
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected word byte %02h kind %0d type %0d count %0d last %0b",
                     $realtime, out_mon.out_byte, out_mon.out_kind, out_mon.tok_type,
                     out_mon.tok_count, out_mon.run_last);
        end else begin
          head_word = expected_words.pop_front();
          if (out_mon.out_byte !== head_word.out_byte ||
              out_mon.out_kind !== head_word.out_kind ||
              out_mon.tok_type !== head_word.tok_type ||
              out_mon.tok_count !== head_word.tok_count ||
              out_mon.run_last !== head_word.run_last) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: word mismatch, expected byte %02h kind %0d type %0d count %0d last %0b",
                       $realtime, head_word.out_byte, head_word.out_kind, head_word.tok_type,
                       head_word.tok_count, head_word.run_last);
              $display("%0t:                got      byte %02h kind %0d type %0d count %0d last %0b",
                       $realtime, out_mon.out_byte, out_mon.out_kind, out_mon.tok_type,
                       out_mon.tok_count, out_mon.run_last);
            end
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the tokenizer testbench: clock, reset, byte stimulus, result stalls and verdict.
module testbench
  import qplt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DepthBits = 8;
  localparam int          HalfPeriod = 5;
  localparam int          CycleLimit = 400000;
  localparam int          RandomBytes = 150;
  localparam int          LongHold = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } text_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qplt_in_if  in_if();
  qplt_out_if out_if();

  int fail_count, pending, words, lines, tokens;
  int cycles = 0;
  int sent = 0;
  logic quiet = 1'b0;
  logic calm_send = 1'b0;
  logic hold_req = 1'b0;

  text_byte_t line_buf[$];

  quote_paren_line_tokenizer #(.DEPTH_BITS(DepthBits)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  qplt_checker #(.DEPTH_BITS(DepthBits)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_o      (words),
    .lines_o      (lines),
    .tokens_o     (tokens)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Stop a hung run
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  // Drive result ready: random stall bursts, calm stretches and one long hold-off
  initial begin
    int stall;
    int calm;
    int hold;
    out_if.ready = 1'b0;
    stall = 0;
    calm  = 0;
    hold  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold == 0) begin
        hold_req = 1'b0;
        hold     = LongHold;
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (stall > 0 && !quiet) begin
        out_if.ready <= 1'b0;
        stall--;
        if (stall == 0 && $urandom_range(0, 3) == 0) calm = $urandom_range(20, 60);
      end else if (calm > 0) begin
        out_if.ready <= 1'b1;
        calm--;
      end else if (!quiet && rst_ni && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        stall = $urandom_range(1, 19) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void put(logic [7:0] c, logic le = 1'b0);
    line_buf.push_back('{ch: c, line_end: le});
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return c inside {[8'd9:8'd13], ChSpace};
  endfunction

  // Any nonzero byte that is no separator
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_sep(c));
    return c;
  endfunction

  function automatic void blanks(int lo, int hi);
    int r;
    repeat ($urandom_range(lo, hi)) begin
      r = $urandom_range(8, 13);
      put((r == 8) ? ChSpace : 8'(r));
    end
  endfunction

  function automatic void regular_token();
    logic [7:0] c;
    do c = text_char(); while (c == ChQuote || c == ChOpen);
    put(c);
    repeat ($urandom_range(0, 5)) put(text_char());
  endfunction

  function automatic void quoted_token(logic closed);
    logic [7:0] c;
    put(ChQuote);
    repeat ($urandom_range(0, 5)) begin
      do c = 8'($urandom_range(1, 255)); while (c == ChQuote);
      put(c);
    end
    if (closed) put(ChQuote);
  endfunction

  function automatic void paren_token(logic closed);
    int depth;
    logic [7:0] c;
    put(ChOpen);
    depth = 1;
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 3))
        0: if (depth < 4) begin
          put(ChOpen);
          depth++;
        end
        1: if (depth > 1) begin
          put(ChClose);
          depth--;
        end
        default: begin
          do c = 8'($urandom_range(1, 255)); while (c == ChOpen || c == ChClose);
          put(c);
        end
      endcase
    end
    if (closed) begin
      repeat (depth) put(ChClose);
    end
  endfunction

  // Well-formed line of random tokens; the last one may be left open
  function automatic void text_line();
    int ntok;
    logic open_end;
    ntok = $urandom_range(0, 6);
    for (int t = 0; t < ntok; t++) begin
      if ($urandom_range(0, 2) == 0) blanks(1, 3);
      open_end = (t == ntok - 1) && ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: begin
          regular_token();
          if (t < ntok - 1 || $urandom_range(0, 1) == 0) blanks(1, 2);
        end
        1: quoted_token(!open_end);
        default: paren_token(!open_end);
      endcase
    end
    if ($urandom_range(0, 1) == 0) blanks(1, 2);
    if (line_buf.size() == 0) put(ChSpace);
    line_buf[line_buf.size()-1].line_end = 1'b1;
  endfunction

  function automatic void noise_line();
    repeat ($urandom_range(1, 10)) put(8'($urandom_range(1, 255)));
    line_buf[line_buf.size()-1].line_end = 1'b1;
  endfunction

  // Offer one byte, at times with a random gap in front, and hold until it is taken
  task automatic offer_byte(input text_byte_t b);
    if (!quiet && !calm_send && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.ch       <= b.ch;
    in_if.line_end <= b.line_end;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) offer_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int start;
    logic hold_done;
    in_if.valid    = 1'b0;
    in_if.ch       = 8'd0;
    in_if.line_end = 1'b0;
    hold_done      = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every word kind and the corner cases
    put(8'hFF); put(8'h01); put(ChSpace);                  // extreme bytes, regular token
    put(ChQuote); put(8'h80); put(ChTab); put(ChQuote);    // blank kept inside quotes
    put(ChQuote); put(ChQuote);                            // empty quotes
    put(ChOpen); put(8'h7F); put(ChOpen); put(ChClose); put(ChClose);
    put(ChOpen); put(ChClose); put("b", 1'b1);             // no separator after parens
    put(8'h00); put(ChCr, 1'b1);                           // zero byte is plain text
    put(ChQuote); put("q", 1'b1);                          // line ends inside quotes
    put(ChOpen); put(ChSpace, 1'b1);                       // line ends inside parentheses
    put(8'h0B, 1'b1);                                      // separators only
    put(ChQuote, 1'b1);                                    // quote on the last byte
    send_buf();

    // Pause until every expected word is back
    drain();

    // Random lines, mostly well formed, with one long receiver hold-off
    start = sent;
    while (sent < start + RandomBytes) begin
      if (!hold_done && sent > start + 60) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      calm_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) noise_line();
      else text_line();
      send_buf();
    end
    calm_send = 1'b0;

    // Saturate the token count, then the nesting depth
    repeat (260) begin
      put(ChOpen);
      put(ChClose);
    end
    put(ChSpace, 1'b1);
    send_buf();
    repeat (258) put(ChOpen);
    repeat (3) put(ChClose);
    put("x", 1'b1);
    send_buf();

    // Closing stretch without any idling
    drain();
    quiet = 1'b1;
    repeat (6) begin
      text_line();
      send_buf();
    end

    drain();
    repeat (8) @(negedge clk_i);
    $display("Covered %0d bytes in %0d lines, incl. saturated token count and depth;",
             sent, lines);
    $display("%0d result words checked, %0d tokens committed.", words, tokens);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/qplt_pkg.sv
sv/qplt_if.sv
sv/qplt_scan.sv
sv/qplt_outbuf.sv
sv/quote_paren_line_tokenizer.sv
tb/qplt_checker.sv
tb/testbench.sv
